// ----- hw/rtl/bq2_pkg.sv -----
package bq2_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int ACC_W        = 40;
  localparam logic signed [31:0] GAIN_RESET = 32'sd268435456;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Register indexes on the write port; the spare ones change nothing.
  typedef enum logic [2:0] {
    REG_GAIN,
    REG_FB1,
    REG_FF1,
    REG_FB2,
    REG_FF2,
    REG_SPARE5,
    REG_SPARE6,
    REG_SPARE7
  } reg_index_t;

  // One history row per channel: both delay words of both sections.
  typedef struct packed {
    logic signed [31:0] h2b;
    logic signed [31:0] h1b;
    logic signed [31:0] h2a;
    logic signed [31:0] h1a;
  } hist_row_t;

  typedef struct packed {
    logic signed [31:0] gain;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a3;
    logic signed [31:0] a4;
    logic signed [31:0] b3;
    logic signed [31:0] b4;
  } coef_t;

  // Product order through the shared multiplier.
  typedef enum logic [3:0] {
    STEP_GAIN,
    STEP_FB1_H1,
    STEP_FB1_H2,
    STEP_FF1_H1,
    STEP_FF1_H2,
    STEP_FB2_H1,
    STEP_FB2_H2,
    STEP_FF2_H1,
    STEP_FF2_H2
  } step_t;

  typedef struct packed {
    logic  issue;
    step_t step;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(acc_t v);
    if (v[ACC_W-1:31] == {(ACC_W-31){v[ACC_W-1]}}) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  function automatic logic signed [23:0] sat24(acc_t v);
    if (v[ACC_W-1:23] == {(ACC_W-23){v[ACC_W-1]}}) begin
      return v[23:0];
    end
    return v[ACC_W-1] ? 24'sh800000 : 24'sh7fffff;
  endfunction

  function automatic acc_t ext32(logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage

// ----- hw/rtl/two_section_biquad_cascade.sv -----
// Two-section direct form II biquad cascade for up to CHANNELS interleaved
// audio channels. Each request carries a signed 24-bit sample and its channel;
// the result is the filtered sample, saturated to 24 bits, with the same
// channel, one result per request and in request order. A request reads the
// channel's history row, runs its products through the single shared 32x32
// multiplier (input gain, then four products per section), drains the multiplier
// register, then writes the history back and loads the output register. A
// second request waits in the input register while one is in the engine, and
// a finished result waits in the output register without holding up the engine
// until the next one is ready. Coefficients are signed Q4.28; the user must
// write them through the register port only while the block is idle; the block
// itself does not enforce this. Pair registers hold the first coefficient in
// bits 31..0 and the second in bits 63..32. History is all zero after reset
// through per-channel valid bits, so there is no clearing sweep. Channels at
// or above CHANNELS are filtered with zero history and leave no state.
module two_section_biquad_cascade #(
  parameter int CHANNELS = bq2_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [23:0] sample_in,
  input  logic [2:0]         channel_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [23:0] sample_out,
  output logic [2:0]         channel_out,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data
);
  import bq2_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DRAIN, S_DONE} state_t;

  coef_t              coef;
  state_t             state;
  step_t              step;

  // input register
  logic               buf_full;
  logic signed [23:0] buf_x;
  logic [2:0]         buf_ch;

  // request in the engine
  logic signed [23:0] cur_x;
  logic [2:0]         cur_ch;

  // output register
  logic               res_valid;
  logic signed [23:0] res_sample;
  logic [2:0]         res_ch;

  logic               take;
  logic               out_free;
  mac_ctl_t           mac_ctl;
  hist_row_t          hist;
  hist_row_t          wb_row;
  acc_t               acc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      // gain is the top word of the coefficient set, all pairs zero
      coef <= {GAIN_RESET, 256'd0};
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAIN: coef.gain <= wr_data[31:0];
        REG_FB1:  begin coef.a1 <= wr_data[31:0]; coef.a2 <= wr_data[63:32]; end
        REG_FF1:  begin coef.b1 <= wr_data[31:0]; coef.b2 <= wr_data[63:32]; end
        REG_FB2:  begin coef.a3 <= wr_data[31:0]; coef.a4 <= wr_data[63:32]; end
        REG_FF2:  begin coef.b3 <= wr_data[31:0]; coef.b4 <= wr_data[63:32]; end
        default:  ;
      endcase
    end
  end

  assign take         = (state == S_IDLE) && buf_full;
  assign out_free     = !res_valid || !result_stall;
  // the input register frees up in the same cycle the engine takes it
  assign sample_stall = buf_full && !take;

  assign result_valid = res_valid;
  assign sample_out   = res_sample;
  assign channel_out  = res_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_GAIN;
      buf_full  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        buf_full <= 1'b1;
        buf_x    <= sample_in;
        buf_ch   <= channel_in;
      end else if (take) begin
        buf_full <= 1'b0;
      end

      // a new result replaces the one leaving in the same cycle
      if ((state == S_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !result_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (buf_full) begin
            cur_x  <= buf_x;
            cur_ch <= buf_ch;
            step   <= STEP_GAIN;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == STEP_FF2_H2) begin
            state <= S_DRAIN;
          end else begin
            step <= step_t'(step + 4'd1);
          end
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          // history write and result load happen together, so the next
          // read of the same channel always sees the new row
          if (out_free) begin
            res_sample <= sat24(acc);
            res_ch     <= cur_ch;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mac_ctl.issue = (state == S_MUL);
  assign mac_ctl.step  = step;

  bq2_hist_mem #(
    .CHANNELS(CHANNELS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (take),
    .rd_ch  (buf_ch),
    .rd_row (hist),
    .wr_en  ((state == S_DONE) && out_free),
    .wr_ch  (cur_ch),
    .wr_row (wb_row)
  );

  bq2_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .x      (cur_x),
    .coef   (coef),
    .hist   (hist),
    .acc    (acc),
    .wb_row (wb_row)
  );

endmodule

// ----- hw/rtl/bq2_hist_mem.sv -----
module bq2_hist_mem #(
  parameter int CHANNELS = bq2_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [2:0]        rd_ch,
  output bq2_pkg::hist_row_t rd_row,
  input  logic              wr_en,
  input  logic [2:0]        wr_ch,
  input  bq2_pkg::hist_row_t wr_row
);
  import bq2_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  hist_row_t           mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  hist_row_t           rd_q;
  logic                rd_live;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       wr_idx;
  logic                rd_ok;
  logic                wr_ok;

  assign rd_idx = AW'(rd_ch);
  assign wr_idx = AW'(wr_ch);
  // channels past the store read as zero history and are never written
  assign rd_ok  = 32'(rd_ch) < CHANNELS;
  assign wr_ok  = 32'(wr_ch) < CHANNELS;

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en && rd_ok) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en && wr_ok) begin
        vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= rd_ok && vld[rd_idx];
      end
    end
  end

  assign rd_row = rd_live ? rd_q : '0;

endmodule

// ----- hw/rtl/bq2_mac.sv -----
module bq2_mac (
  input  logic               clk,
  input  logic               rst,
  input  bq2_pkg::mac_ctl_t  ctl,
  input  logic signed [23:0] x,
  input  bq2_pkg::coef_t     coef,
  input  bq2_pkg::hist_row_t hist,
  output bq2_pkg::acc_t      acc,
  output bq2_pkg::hist_row_t wb_row
);
  import bq2_pkg::*;

  logic signed [31:0] a_op;
  logic signed [31:0] c_op;
  logic signed [63:0] prod;
  logic               p_live;
  step_t              p_step;
  acc_t               q;
  acc_t               acc_next;
  logic signed [31:0] w1;
  logic signed [31:0] w2;

  always_comb begin
    a_op = '0;
    c_op = '0;
    case (ctl.step)
      STEP_GAIN:   begin a_op = {{8{x[23]}}, x}; c_op = coef.gain; end
      STEP_FB1_H1: begin a_op = hist.h1a; c_op = coef.a1; end
      STEP_FB1_H2: begin a_op = hist.h2a; c_op = coef.a2; end
      STEP_FF1_H1: begin a_op = hist.h1a; c_op = coef.b1; end
      STEP_FF1_H2: begin a_op = hist.h2a; c_op = coef.b2; end
      STEP_FB2_H1: begin a_op = hist.h1b; c_op = coef.a3; end
      STEP_FB2_H2: begin a_op = hist.h2b; c_op = coef.a4; end
      STEP_FF2_H1: begin a_op = hist.h1b; c_op = coef.b3; end
      STEP_FF2_H2: begin a_op = hist.h2b; c_op = coef.b4; end
      default:     ;
    endcase
  end

  // product >>> 28, floor rounding
  assign q = {{(ACC_W-36){prod[63]}}, prod[63:28]};

  // each section starts from the saturated value of the one before
  always_comb begin
    case (p_step)
      STEP_GAIN:   acc_next = q;
      STEP_FB1_H1: acc_next = ext32(sat32(acc)) - q;
      STEP_FF1_H1: acc_next = ext32(sat32(acc)) + q;
      STEP_FB2_H1: acc_next = ext32(sat32(acc)) - q;
      STEP_FF2_H1: acc_next = ext32(sat32(acc)) + q;
      STEP_FB1_H2: acc_next = acc - q;
      STEP_FB2_H2: acc_next = acc - q;
      STEP_FF1_H2: acc_next = acc + q;
      STEP_FF2_H2: acc_next = acc + q;
      default:     acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_live <= 1'b0;
    end else begin
      p_live <= ctl.issue;
    end
    if (ctl.issue) begin
      prod   <= 64'(a_op) * 64'(c_op);
      p_step <= ctl.step;
    end
    if (p_live) begin
      acc <= acc_next;
      if (p_step == STEP_FF1_H1) begin
        w1 <= sat32(acc);
      end
      if (p_step == STEP_FF2_H1) begin
        w2 <= sat32(acc);
      end
    end
  end

  always_comb begin
    wb_row.h1a = w1;
    wb_row.h2a = hist.h1a;
    wb_row.h1b = w2;
    wb_row.h2b = hist.h1b;
  end

endmodule

// ----- hw/rtl/bq2_checker.sv -----
module bq2_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [23:0] sample_out,
  input logic [2:0]  channel_out
);

  logic [2:0] inflight;
  logic       req_in;
  logic       req_out;

  assign req_in  = sample_valid && !sample_stall;
  assign req_out = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(req_in) - 3'(req_out);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(sample_out)
      && $stable(channel_out))
    else $error("stalled result changed");

  // reset leaves no result and an open input
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("state left after reset");

  // input register, engine and output register: at most three requests
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd3)
    else $error("too many requests in flight");

  // no result without a request behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> inflight != 3'd0)
    else $error("result without request");

endmodule

bind two_section_biquad_cascade bq2_checker u_bq2_checker (.*);
